// ===== design/content_bounding_box_defines.svh =====
// Assertion macros used by the bounding box top level.
`ifndef CONTENT_BOUNDING_BOX_DEFINES_SVH
`define CONTENT_BOUNDING_BOX_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define CBB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define CBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cbb_pkg.sv =====
// Package with the shared types and constants of the bounding box block.
package cbb_pkg;

  localparam int unsigned MaxDimensionDef = 4096;
  localparam int unsigned CfgW            = 13;
  localparam int unsigned PixelW          = 32;
  localparam int unsigned EdgeLoW         = 12;
  localparam int unsigned EdgeHiW         = 13;
  localparam int unsigned OutDataW        = 56;

  localparam logic [PixelW-1:0] AlphaMask  = 32'hff00_0000;
  localparam logic [PixelW-1:0] RedMask    = 32'h00ff_0000;
  localparam logic [PixelW-1:0] GreenMask  = 32'h0000_ff00;
  localparam logic [PixelW-1:0] BlueMask   = 32'h0000_00ff;
  localparam logic [7:0]        ByteFull   = 8'd255;

  // Register indexes of the configuration port.
  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  // Classified pixel handed from the input stage to the tracker.
  typedef struct packed {
    logic valid;
    logic content;
  } pix_t;

  // One bounding box result.
  typedef struct packed {
    logic               empty;
    logic [EdgeHiW-1:0] bottom;
    logic [EdgeHiW-1:0] right;
    logic [EdgeLoW-1:0] top;
    logic [EdgeLoW-1:0] left;
  } box_t;

  // A pixel is background when alpha is zero or all colour bytes are full.
  function automatic logic is_background(input logic [PixelW-1:0] p);
    logic alpha_zero;
    logic colour_full;
    alpha_zero  = (p & AlphaMask) == '0;
    colour_full = ((p & RedMask) == (RedMask & {PixelW{1'b1}})) &&
                  ((p & GreenMask) == GreenMask) &&
                  ((p & BlueMask) == {24'd0, ByteFull});
    return alpha_zero || colour_full;
  endfunction

endpackage

// ===== design/cbb_pix_stage.sv =====
// Input register stage: takes a pixel item and registers its content flag.
module cbb_pix_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cbb_pkg::PixelW-1:0] in_pixel_i,
  input  logic                       take_i,
  output cbb_pkg::pix_t              pix_o
);

  logic valid_q, valid_d;
  logic content_q;
  logic load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      content_q <= !cbb_pkg::is_background(in_pixel_i);
    end
  end

  assign pix_o.valid   = valid_q;
  assign pix_o.content = content_q;

endmodule

// ===== design/cbb_box_track.sv =====
// Frame position counters, size registers and running content box.
module cbb_box_track #(
  parameter int unsigned MAX_DIMENSION = cbb_pkg::MaxDimensionDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [cbb_pkg::CfgW-1:0] cfg_data_i,
  input  cbb_pkg::pix_t            pix_i,
  input  logic                     out_free_i,
  output logic                     take_o,
  output logic                     res_valid_o,
  output cbb_pkg::box_t            res_o
);

  localparam int unsigned CntW = $clog2(MAX_DIMENSION);
  localparam int unsigned CmpW = (CntW + 1 > cbb_pkg::CfgW) ? CntW + 1 : cbb_pkg::CfgW;

  logic [cbb_pkg::CfgW-1:0] width_q, height_q;
  logic [CmpW-1:0]          width_ext, height_ext, eff_w, eff_h;
  logic [CntW-1:0]          last_col, last_row;
  logic [CntW-1:0]          col_q, col_d, row_q, row_d;
  logic [CntW-1:0]          min_col_q, min_col_d, max_col_q, max_col_d;
  logic [CntW-1:0]          min_row_q, min_row_d, max_row_q, max_row_d;
  logic                     seen_q, seen_d;
  logic [CntW-1:0]          min_col_n, max_col_n, min_row_n, max_row_n;
  logic                     seen_n, hit, row_end, is_last_row, frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= cbb_pkg::CfgW'(1);
      height_q <= cbb_pkg::CfgW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cbb_pkg::RegFrameWidth:  width_q  <= cfg_data_i;
        cbb_pkg::RegFrameHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero counts as one and anything above the limit is clamped to it.
  assign width_ext  = CmpW'(width_q);
  assign height_ext = CmpW'(height_q);
  assign eff_w = (width_ext == '0) ? CmpW'(1) :
                 (width_ext > CmpW'(MAX_DIMENSION)) ? CmpW'(MAX_DIMENSION) : width_ext;
  assign eff_h = (height_ext == '0) ? CmpW'(1) :
                 (height_ext > CmpW'(MAX_DIMENSION)) ? CmpW'(MAX_DIMENSION) : height_ext;
  assign last_col = CntW'(eff_w - CmpW'(1));
  assign last_row = CntW'(eff_h - CmpW'(1));

  assign row_end     = col_q >= last_col;
  assign is_last_row = row_q >= last_row;
  assign frame_end   = row_end && is_last_row;

  // An item with no result always moves on; a frame end needs a free output.
  assign take_o      = pix_i.valid && (!frame_end || out_free_i);
  assign res_valid_o = take_o && frame_end;
  assign hit         = pix_i.valid && pix_i.content;

  always_comb begin
    min_col_n = min_col_q;
    max_col_n = max_col_q;
    min_row_n = min_row_q;
    max_row_n = max_row_q;
    if (hit && !seen_q) begin
      min_col_n = col_q;
      max_col_n = col_q;
      min_row_n = row_q;
      max_row_n = row_q;
    end else if (hit) begin
      min_col_n = (col_q < min_col_q) ? col_q : min_col_q;
      max_col_n = (col_q > max_col_q) ? col_q : max_col_q;
      min_row_n = (row_q < min_row_q) ? row_q : min_row_q;
      max_row_n = (row_q > max_row_q) ? row_q : max_row_q;
    end
    seen_n = seen_q || hit;
  end

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    min_col_d = min_col_q;
    max_col_d = max_col_q;
    min_row_d = min_row_q;
    max_row_d = max_row_q;
    seen_d    = seen_q;
    if (take_o) begin
      if (frame_end) begin
        col_d     = '0;
        row_d     = '0;
        min_col_d = '0;
        max_col_d = '0;
        min_row_d = '0;
        max_row_d = '0;
        seen_d    = 1'b0;
      end else begin
        min_col_d = min_col_n;
        max_col_d = max_col_n;
        min_row_d = min_row_n;
        max_row_d = max_row_n;
        seen_d    = seen_n;
        if (row_end) begin
          col_d = '0;
          row_d = row_q + CntW'(1);
        end else begin
          col_d = col_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      min_col_q <= '0;
      max_col_q <= '0;
      min_row_q <= '0;
      max_row_q <= '0;
      seen_q    <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      min_col_q <= min_col_d;
      max_col_q <= max_col_d;
      min_row_q <= min_row_d;
      max_row_q <= max_row_d;
      seen_q    <= seen_d;
    end
  end

  always_comb begin
    if (seen_n) begin
      res_o.left   = cbb_pkg::EdgeLoW'(min_col_n);
      res_o.top    = cbb_pkg::EdgeLoW'(min_row_n);
      res_o.right  = cbb_pkg::EdgeHiW'(max_col_n);
      res_o.bottom = cbb_pkg::EdgeHiW'(max_row_n);
      res_o.empty  = 1'b0;
    end else begin
      res_o.left   = '0;
      res_o.top    = '0;
      res_o.right  = cbb_pkg::EdgeHiW'(eff_w);
      res_o.bottom = cbb_pkg::EdgeHiW'(eff_h);
      res_o.empty  = 1'b1;
    end
  end

endmodule

// ===== design/cbb_out_stage.sv =====
// Result register that holds a box item until the downstream side takes it.
module cbb_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  cbb_pkg::box_t res_i,
  output logic          out_free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cbb_pkg::box_t out_box_o
);

  logic          valid_q, valid_d;
  cbb_pkg::box_t box_q;

  assign out_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      box_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_box_o   = box_q;

endmodule

// ===== design/content_bounding_box.sv =====
// Top level of the content bounding box block for raster pixel streams.
//
//   Channel    Direction  Handshake                     Payload
//   s_axis     in         s_axis_tvalid/s_axis_tready   one pixel per item
//   m_axis     out        m_axis_tvalid/m_axis_tready   one box per frame
//   cfg        in         cfg_we_i (always taken)       frame width / height
//
// One pixel item is accepted every clock cycle when the result side does not
// stall. A pixel is registered and classified in the input register, then
// folded into the running box by the tracker; the box of a frame appears on
// m_axis the cycle after its last pixel leaves the input register. Reset
// clears the position counters and the box, sets both frame sizes to one and
// needs no clearing pass. Only the last pixel of a frame waits on a full
// result register; all other pixels keep flowing while a result waits to be
// taken.
module content_bounding_box #(
  parameter int unsigned MAX_DIMENSION = cbb_pkg::MaxDimensionDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Pixel input.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [cbb_pkg::PixelW-1:0]   s_axis_tdata,   // [31:0] pixel_word
  // Box output.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [cbb_pkg::OutDataW-1:0] m_axis_tdata,   // [11:0] left_edge,
                                                       // [23:12] top_edge,
                                                       // [36:24] right_edge,
                                                       // [49:37] bottom_edge,
                                                       // [55:50] zero
  output logic                         m_axis_tuser,   // [0] frame_empty
  // Configuration writes.
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [cbb_pkg::CfgW-1:0]     cfg_data_i
);

  `include "content_bounding_box_defines.svh"

  cbb_pkg::pix_t pix;
  cbb_pkg::box_t res_box;
  cbb_pkg::box_t out_box;
  logic          take;
  logic          res_valid;
  logic          out_free;

  // Stage one: register the pixel and decide content versus background.
  cbb_pix_stage u_pix_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_pixel_i (s_axis_tdata),
    .take_i     (take),
    .pix_o      (pix)
  );

  // Stage two: advance the raster position, grow the box, close the frame.
  cbb_box_track #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_box_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (pix),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res_box)
  );

  // The result register parts the pixel pipe from the result consumer.
  cbb_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_box),
    .out_free_o  (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_box_o   (out_box)
  );

  assign m_axis_tdata = {6'd0, out_box.bottom, out_box.right, out_box.top, out_box.left};
  assign m_axis_tuser = out_box.empty;

  // A frame with no content reports its box starting at the origin.
  `CBB_ASSERT_IMPL(a_empty_origin, m_axis_tvalid && m_axis_tuser, m_axis_tdata[23:0] == 24'd0, "empty frame box does not start at the origin")

  // A closed frame always reaches the result register in the next cycle.
  `CBB_ASSERT_NEXT(a_result_lands, res_valid, m_axis_tvalid, "frame result was lost")

  // A frame may only close when the result register can take the box.
  `CBB_ASSERT_IMPL(a_no_overwrite, res_valid, out_free, "frame result overwrote a pending box")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the content bounding box block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Covers the path from the last pixel of a frame to its box, plus margin. Used
  // before a size write while a frame may still be half done.
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned RandomPixels  = 1475;
  localparam int unsigned EdgeRunPixels = 200;
  localparam int unsigned ReportLimit   = 10;

  // Pixels that sit on the edges of the background test, one 1x1 frame each.
  localparam logic [cbb_pkg::PixelW-1:0] CornerPixels [9] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h00ff_ffff, 32'h0100_0000, 32'hff00_0000,
    32'hffff_fffe, 32'h80fe_ffff, 32'h7fff_7fff, 32'h01ff_ffff
  };

  typedef enum int {FILL_EMPTY, FILL_SINGLE, FILL_SPARSE, FILL_DENSE, FILL_FULL} fill_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_BLOCKED} rx_mode_e;

  // Tracks the frame position and content box, and holds the boxes still
  // owed by the block in arrival order.
  class box_scoreboard;
    logic [cbb_pkg::CfgW-1:0] width_reg  = cbb_pkg::CfgW'(1);
    logic [cbb_pkg::CfgW-1:0] height_reg = cbb_pkg::CfgW'(1);
    int unsigned     col_pos, row_pos, min_col, max_col, min_row, max_row;
    bit              seen;
    cbb_pkg::box_t   owed_boxes[$];
    int unsigned     mismatches;

    function int unsigned clamp_size(logic [cbb_pkg::CfgW-1:0] v);
      if (v == 0) return 1;
      if (v > cbb_pkg::MaxDimensionDef) return cbb_pkg::MaxDimensionDef;
      return v;
    endfunction

    function void write_reg(logic idx, logic [cbb_pkg::CfgW-1:0] value);
      if (idx == cbb_pkg::RegFrameWidth) width_reg = value;
      else height_reg = value;
    endfunction

    function int unsigned pending();
      return owed_boxes.size();
    endfunction

    function void note_pixel(logic [cbb_pkg::PixelW-1:0] pixel);
      int unsigned   w;
      int unsigned   h;
      bit            row_end;
      bit            last_row;
      cbb_pkg::box_t box;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      row_end  = col_pos >= w - 1;
      last_row = row_pos >= h - 1;
      // Content unless alpha is clear or the colour is pure white.
      if (pixel[31:24] != 8'h00 && pixel[23:0] != 24'hff_ffff) begin
        if (!seen) begin
          min_col = col_pos;
          max_col = col_pos;
          min_row = row_pos;
          max_row = row_pos;
          seen    = 1'b1;
        end else begin
          if (col_pos < min_col) min_col = col_pos;
          if (col_pos > max_col) max_col = col_pos;
          if (row_pos < min_row) min_row = row_pos;
          if (row_pos > max_row) max_row = row_pos;
        end
      end
      if (row_end && last_row) begin
        box.empty = !seen;
        if (seen) begin
          box.left   = cbb_pkg::EdgeLoW'(min_col);
          box.top    = cbb_pkg::EdgeLoW'(min_row);
          box.right  = cbb_pkg::EdgeHiW'(max_col);
          box.bottom = cbb_pkg::EdgeHiW'(max_row);
        end else begin
          box.left   = '0;
          box.top    = '0;
          box.right  = cbb_pkg::EdgeHiW'(w);
          box.bottom = cbb_pkg::EdgeHiW'(h);
        end
        owed_boxes.push_back(box);
        col_pos = 0;
        row_pos = 0;
        min_col = 0;
        max_col = 0;
        min_row = 0;
        max_row = 0;
        seen    = 1'b0;
      end else if (row_end) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
    endfunction

    function void flag(string field, longint unsigned want, longint unsigned got);
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("box mismatch in %s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_box(logic [cbb_pkg::OutDataW-1:0] data, logic empty);
      cbb_pkg::box_t want;
      cbb_pkg::box_t got;
      got = {empty, data[49:0]};
      if (owed_boxes.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("box arrived with none owed: data %h, empty %b", data, empty);
        return;
      end
      want = owed_boxes.pop_front();
      if (got.left != want.left) flag("left_edge", want.left, got.left);
      if (got.top != want.top) flag("top_edge", want.top, got.top);
      if (got.right != want.right) flag("right_edge", want.right, got.right);
      if (got.bottom != want.bottom) flag("bottom_edge", want.bottom, got.bottom);
      if (got.empty != want.empty) flag("frame_empty", want.empty, got.empty);
      if (data[cbb_pkg::OutDataW-1:50] != '0)
        flag("tdata padding", 0, data[cbb_pkg::OutDataW-1:50]);
    endfunction
  endclass

  logic                         clk_i    = 1'b0;
  logic                         rst_ni   = 1'b0;
  logic                         s_valid  = 1'b0;
  logic [cbb_pkg::PixelW-1:0]   s_data   = '0;
  logic                         m_ready  = 1'b0;
  logic                         cfg_we   = 1'b0;
  logic                         cfg_idx  = cbb_pkg::RegFrameWidth;
  logic [cbb_pkg::CfgW-1:0]     cfg_data = '0;
  logic                         s_ready;
  logic                         m_valid;
  logic [cbb_pkg::OutDataW-1:0] m_data;
  logic                         m_user;

  box_scoreboard box_sb;
  int unsigned   quiet_cycles = 0;
  int            burst_left   = 0;
  rx_mode_e      rx_mode      = RX_OPEN;
  int            rx_left      = 0;
  bit            timed_out    = 1'b0;

  always #6 clk_i = ~clk_i;

  content_bounding_box dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  // Result side: stretches of free flow, coin flips, slow draining and hard
  // stalls, each of random length.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = (rx_mode == RX_BLOCKED) ? $urandom_range(1, 20) : $urandom_range(5, 80);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:    m_ready <= 1'b1;
      RX_COIN:    m_ready <= 1'($urandom_range(0, 1));
      RX_SLOW:    m_ready <= ($urandom_range(0, 3) == 0);
      default:    m_ready <= 1'b0;
    endcase
  end

  // Every handshake is taken at the rising edge, where block outputs still
  // hold their values from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) box_sb.write_reg(cfg_idx, cfg_data);
      if (s_valid && s_ready) box_sb.note_pixel(s_data);
      if (m_valid && m_ready) box_sb.check_box(m_data, m_user);
      if (cfg_we || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  function automatic logic [cbb_pkg::PixelW-1:0] background_pixel();
    logic [cbb_pkg::PixelW-1:0] p;
    p = $urandom;
    if ($urandom_range(0, 1)) p[31:24] = 8'h00;
    else p[23:0] = 24'hff_ffff;
    return p;
  endfunction

  function automatic logic [cbb_pkg::PixelW-1:0] content_pixel();
    logic [cbb_pkg::PixelW-1:0] p;
    p = $urandom;
    if (p[31:24] == 8'h00) p[31:24] = 8'($urandom_range(1, 255));
    // Near-white colours sit right next to the background test.
    if ($urandom_range(0, 3) == 0) p[23:0] = 24'hff_ffff ^ (24'h1 << $urandom_range(0, 23));
    if (p[23:0] == 24'hff_ffff) p[0] = 1'b0;
    return p;
  endfunction

  // Entered after a rising edge; returns at the edge that takes the pixel.
  task automatic push_pixel(input logic [cbb_pkg::PixelW-1:0] pixel);
    @(negedge clk_i);
    if (burst_left <= 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= pixel;
    do @(posedge clk_i); while (!s_ready);
  endtask

  task automatic send_frame(input int unsigned count, input fill_e fill,
                            input int unsigned hit);
    bit is_content;
    for (int unsigned i = 0; i < count; i++) begin
      case (fill)
        FILL_EMPTY:  is_content = 1'b0;
        FILL_SINGLE: is_content = (i == hit);
        FILL_SPARSE: is_content = ($urandom_range(0, 4) == 0);
        FILL_DENSE:  is_content = ($urandom_range(0, 9) < 7);
        default:     is_content = 1'b1;
      endcase
      push_pixel(is_content ? content_pixel() : background_pixel());
    end
  endtask

  // Bring the block to rest: all boxes owed have arrived and any pixel still
  // inside the pipe has been folded in.
  task automatic settle();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (box_sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [cbb_pkg::CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [cbb_pkg::CfgW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 60) return cbb_pkg::CfgW'($urandom_range(1, 6));
    if (r < 90) return cbb_pkg::CfgW'($urandom_range(7, 24));
    return cbb_pkg::CfgW'($urandom_range(25, 80));
  endfunction

  task automatic run_random();
    int unsigned              sent;
    int unsigned              area;
    logic [cbb_pkg::CfgW-1:0] w;
    logic [cbb_pkg::CfgW-1:0] h;
    sent = 0;
    while (sent < RandomPixels) begin
      settle();
      w = pick_size();
      h = pick_size();
      if ((w == 0 ? 1 : w) * (h == 0 ? 1 : h) > 400) h = cbb_pkg::CfgW'($urandom_range(1, 3));
      case ($urandom_range(0, 2))
        0: write_reg(cbb_pkg::RegFrameWidth, w);
        1: write_reg(cbb_pkg::RegFrameHeight, h);
        default: begin
          write_reg(cbb_pkg::RegFrameWidth, w);
          write_reg(cbb_pkg::RegFrameHeight, h);
        end
      endcase
      w = cbb_pkg::CfgW'(box_sb.clamp_size(box_sb.width_reg));
      h = cbb_pkg::CfgW'(box_sb.clamp_size(box_sb.height_reg));
      area = w * h;
      repeat ($urandom_range(1, 3)) begin
        send_frame(area, fill_e'($urandom_range(0, 4)), $urandom_range(0, area - 1));
        sent += area;
      end
      // Now and then stop inside a frame so the next size lands mid-frame.
      if (area > 1 && $urandom_range(0, 4) == 0) begin
        area = $urandom_range(1, area - 1);
        send_frame(area, FILL_SPARSE, 0);
        sent += area;
      end
    end
  endtask

  initial begin
    box_sb = new;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fork
      begin
        // Reset sizes give 1x1 frames: each pixel is a whole frame.
        foreach (CornerPixels[i]) push_pixel(CornerPixels[i]);
        settle();
        // Zero sizes count as one.
        write_reg(cbb_pkg::RegFrameWidth, '0);
        write_reg(cbb_pkg::RegFrameHeight, '0);
        push_pixel(32'h4000_0000);
        push_pixel(32'h0012_3456);
        settle();
        // Content only in the last column still makes a non-empty frame.
        write_reg(cbb_pkg::RegFrameWidth, cbb_pkg::CfgW'(3));
        write_reg(cbb_pkg::RegFrameHeight, cbb_pkg::CfgW'(2));
        send_frame(6, FILL_SINGLE, 2);
        settle();
        // Shrink the width inside a frame: the column counter is already at
        // the new last column, so the next pixel closes the frame.
        write_reg(cbb_pkg::RegFrameWidth, cbb_pkg::CfgW'(4));
        send_frame(5, FILL_SPARSE, 0);
        settle();
        write_reg(cbb_pkg::RegFrameWidth, cbb_pkg::CfgW'(2));
        push_pixel(content_pixel());
        settle();
        // Top register values: a long row stays open under the clamped width
        // until a smaller width closes it, then the same for the rows.
        write_reg(cbb_pkg::RegFrameWidth, 13'h1fff);
        write_reg(cbb_pkg::RegFrameHeight, cbb_pkg::CfgW'(1));
        send_frame(EdgeRunPixels, FILL_SINGLE, EdgeRunPixels - 1);
        settle();
        write_reg(cbb_pkg::RegFrameWidth, cbb_pkg::CfgW'(2));
        push_pixel(background_pixel());
        settle();
        write_reg(cbb_pkg::RegFrameWidth, cbb_pkg::CfgW'(1));
        write_reg(cbb_pkg::RegFrameHeight, 13'h1fff);
        send_frame(EdgeRunPixels, FILL_SPARSE, 0);
        settle();
        write_reg(cbb_pkg::RegFrameHeight, cbb_pkg::CfgW'(1));
        push_pixel(background_pixel());

        run_random();

        @(negedge clk_i);
        s_valid <= 1'b0;
        while (box_sb.pending() != 0) @(posedge clk_i);
        repeat (8) @(posedge clk_i);
      end
      begin
        wait (quiet_cycles >= IdleLimit);
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && box_sb.mismatches == 0 && box_sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
